// File: hw/rtl/mi3_pkg.sv
// Shared types, widths and index tables for the 3x3 matrix inverse pipeline.
package mi3_pkg;

    localparam int ELEM_W  = 32;
    localparam int NUM_EL  = 9;
    localparam int ADJ_W   = 64;
    localparam int DET_W   = 98;
    localparam int REM_W   = DET_W + 1;
    localparam int QUO_W   = 32;
    localparam int FRAC_W  = 32;
    localparam int NUM_ROW = 3;

    localparam logic [QUO_W-1:0]  SAT_POS       = 32'h7FFF_FFFF;
    localparam logic [QUO_W-1:0]  SAT_NEG       = 32'h8000_0000;
    localparam logic [ELEM_W-1:0] THRESH_RESET  = 32'd1;

    // adj[k] = m[PA]*m[PB] - m[QA]*m[QB], element index is row*3+col
    localparam logic [3:0] ADJ_PA [NUM_EL] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
    localparam logic [3:0] ADJ_PB [NUM_EL] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
    localparam logic [3:0] ADJ_QA [NUM_EL] = '{4'd7, 4'd1, 4'd2, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
    localparam logic [3:0] ADJ_QB [NUM_EL] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

    // first-row cofactors used for the determinant
    localparam logic [3:0] DET_ADJ [NUM_ROW] = '{4'd0, 4'd3, 4'd6};

    typedef logic [NUM_EL-1:0][ELEM_W-1:0] mat_t;
    typedef logic [NUM_EL-1:0][ADJ_W-1:0]  adj_vec_t;

    typedef struct packed {
        logic             singular;
        logic [DET_W-1:0] dmag;
    } div_side_t;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } lane_t;

    typedef lane_t [NUM_EL-1:0] lane_vec_t;

    typedef struct packed {
        logic invertible;
        mat_t b;
    } out_beat_t;

endpackage

// File: hw/rtl/mi3_adjdet.sv
// Input register, adjugate and determinant stages (six pipeline stages).
module mi3_adjdet (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  mi3_pkg::mat_t     in_mat,
    output logic              out_valid,
    output mi3_pkg::adj_vec_t out_adj,
    output logic [mi3_pkg::DET_W-1:0] out_det
);

    logic [5:0] valid_reg;
    mi3_pkg::mat_t     in_reg;
    mi3_pkg::adj_vec_t p_reg, q_reg;
    logic [mi3_pkg::NUM_ROW-1:0][mi3_pkg::ELEM_W-1:0] row2_reg, row3_reg;
    mi3_pkg::adj_vec_t adj3_reg, adj4_reg, adj5_reg, adj6_reg;
    logic [mi3_pkg::NUM_ROW-1:0][63:0] ph_reg;
    logic [mi3_pkg::NUM_ROW-1:0][64:0] pl_reg;
    logic [mi3_pkg::NUM_ROW-1:0][mi3_pkg::DET_W-1:0] term_reg;
    logic [mi3_pkg::DET_W-1:0] det_reg;

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    // stage 1: capture, stage 2: element products
    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg <= in_mat;
            for (int k = 0; k < mi3_pkg::NUM_EL; k++) begin
                p_reg[k] <= $signed(in_reg[mi3_pkg::ADJ_PA[k]])
                          * $signed(in_reg[mi3_pkg::ADJ_PB[k]]);
                q_reg[k] <= $signed(in_reg[mi3_pkg::ADJ_QA[k]])
                          * $signed(in_reg[mi3_pkg::ADJ_QB[k]]);
            end
            for (int j = 0; j < mi3_pkg::NUM_ROW; j++) begin
                row2_reg[j] <= in_reg[j];
            end
        end
    end

    // stage 3: adjugate entries
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < mi3_pkg::NUM_EL; k++) begin
                adj3_reg[k] <= p_reg[k] - q_reg[k];
            end
            row3_reg <= row2_reg;
        end
    end

    // stage 4: split products of first row times cofactors
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < mi3_pkg::NUM_ROW; j++) begin
                ph_reg[j] <= $signed(row3_reg[j])
                           * $signed(adj3_reg[mi3_pkg::DET_ADJ[j]][63:32]);
                pl_reg[j] <= $signed(row3_reg[j])
                           * $signed({1'b0, adj3_reg[mi3_pkg::DET_ADJ[j]][31:0]});
            end
            adj4_reg <= adj3_reg;
        end
    end

    // stage 5: join partial products, stage 6: sum terms
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < mi3_pkg::NUM_ROW; j++) begin
                term_reg[j] <= (mi3_pkg::DET_W'($signed(ph_reg[j])) << 32)
                             + mi3_pkg::DET_W'($signed(pl_reg[j]));
            end
            adj5_reg <= adj4_reg;
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            adj6_reg <= adj5_reg;
        end
    end

    assign out_valid = valid_reg[5];
    assign out_adj   = adj6_reg;
    assign out_det   = det_reg;

endmodule

// File: hw/rtl/mi3_divprep.sv
// Determinant magnitude, singular test and divider lane setup (two stages).
module mi3_divprep (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  mi3_pkg::adj_vec_t in_adj,
    input  logic [mi3_pkg::DET_W-1:0]  in_det,
    input  logic [mi3_pkg::ELEM_W-1:0] thresh,
    output logic              out_valid,
    output mi3_pkg::div_side_t out_side,
    output mi3_pkg::lane_vec_t out_lanes
);

    logic [1:0] valid_reg;
    logic dneg_reg;
    logic [mi3_pkg::DET_W-1:0] dmag_reg;
    mi3_pkg::adj_vec_t adj_reg;
    mi3_pkg::div_side_t side_reg;
    mi3_pkg::lane_vec_t lanes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    // stage 7: sign and magnitude of the determinant
    always_ff @(posedge aclk) begin
        if (adv) begin
            dneg_reg <= in_det[mi3_pkg::DET_W-1];
            dmag_reg <= in_det[mi3_pkg::DET_W-1] ? (~in_det + 1'b1) : in_det;
            adj_reg  <= in_adj;
        end
    end

    // stage 8: threshold compare, adjugate magnitudes and overflow check
    always_ff @(posedge aclk) begin
        logic [mi3_pkg::ADJ_W-1:0] amag;
        if (adv) begin
            side_reg.singular <= dmag_reg <= mi3_pkg::DET_W'({thresh, 32'd0});
            side_reg.dmag     <= dmag_reg;
            for (int k = 0; k < mi3_pkg::NUM_EL; k++) begin
                amag = adj_reg[k][mi3_pkg::ADJ_W-1] ? (~adj_reg[k] + 1'b1) : adj_reg[k];
                lanes_reg[k].neg <= adj_reg[k][mi3_pkg::ADJ_W-1] ^ dneg_reg;
                lanes_reg[k].ovf <= mi3_pkg::DET_W'(amag) >= dmag_reg;
                lanes_reg[k].rem <= mi3_pkg::REM_W'(amag);
                lanes_reg[k].quo <= '0;
            end
        end
    end

    assign out_valid = valid_reg[1];
    assign out_side  = side_reg;
    assign out_lanes = lanes_reg;

endmodule

// File: hw/rtl/mi3_divstep.sv
// One restoring division step for all nine lanes, one register stage.
module mi3_divstep (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  mi3_pkg::div_side_t in_side,
    input  mi3_pkg::lane_vec_t in_lanes,
    output logic               out_valid,
    output mi3_pkg::div_side_t out_side,
    output mi3_pkg::lane_vec_t out_lanes
);

    logic valid_reg;
    mi3_pkg::div_side_t side_reg;
    mi3_pkg::lane_vec_t lanes_reg;
    mi3_pkg::lane_vec_t lanes_next;

    // shift remainder, subtract divisor when it fits, shift in quotient bit
    always_comb begin
        logic [mi3_pkg::REM_W-1:0] rem2;
        logic                      fits;
        for (int k = 0; k < mi3_pkg::NUM_EL; k++) begin
            rem2 = {in_lanes[k].rem[mi3_pkg::REM_W-2:0], 1'b0};
            fits = rem2 >= mi3_pkg::REM_W'(in_side.dmag);
            lanes_next[k].neg = in_lanes[k].neg;
            lanes_next[k].ovf = in_lanes[k].ovf;
            lanes_next[k].rem = fits ? (rem2 - mi3_pkg::REM_W'(in_side.dmag)) : rem2;
            lanes_next[k].quo = {in_lanes[k].quo[mi3_pkg::QUO_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg  <= in_side;
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_lanes = lanes_reg;

endmodule

// File: hw/rtl/mi3_outq.sv
// Saturation and sign of the quotients, and a two-beat output queue.
module mi3_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  mi3_pkg::div_side_t in_side,
    input  mi3_pkg::lane_vec_t in_lanes,
    output logic               adv,
    output logic               m_tvalid,
    input  logic               m_tready,
    output mi3_pkg::out_beat_t m_beat
);

    mi3_pkg::out_beat_t beat_next;
    mi3_pkg::out_beat_t mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push, pop;

    // format each lane: saturate, apply sign, zero when singular
    always_comb begin
        beat_next.invertible = !in_side.singular;
        for (int k = 0; k < mi3_pkg::NUM_EL; k++) begin
            if (in_side.singular) begin
                beat_next.b[k] = '0;
            end else if (in_lanes[k].ovf) begin
                beat_next.b[k] = in_lanes[k].neg ? mi3_pkg::SAT_NEG : mi3_pkg::SAT_POS;
            end else if (!in_lanes[k].neg) begin
                beat_next.b[k] = (in_lanes[k].quo > mi3_pkg::SAT_POS) ? mi3_pkg::SAT_POS
                                                                      : in_lanes[k].quo;
            end else begin
                beat_next.b[k] = (in_lanes[k].quo > mi3_pkg::SAT_NEG) ? mi3_pkg::SAT_NEG
                                                                      : (~in_lanes[k].quo + 1'b1);
            end
        end
    end

    // pipeline moves while the queue has a free slot
    assign adv  = (cnt_reg != 2'd2);
    assign push = adv && in_valid;
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= beat_next;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_beat   = mem_reg[rd_ptr_reg];

endmodule

// File: hw/rtl/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse: register, pipeline chain and assertions.
//
// Usage:
//   s_ channel: one beat carries one 3x3 matrix of signed Q16.16 elements.
//   m_ channel: one beat per matrix, nine Q16.16 inverse elements in tdata,
//   tuser set when the matrix is invertible. A singular matrix (determinant
//   magnitude at or below singular_threshold) gives tuser low, tdata zero.
//   cfg_ channel: writes singular_threshold (unsigned Q16.16); always ready.
//   Write it only while no matrix is in flight.
// Throughput: one matrix per clock while not stalled. The pipeline is
//   40 register stages: six for adjugate and determinant, two for magnitude
//   and threshold, and 32 for the quotient, one restoring step per stage over
//   all nine lanes.
// Stall: a two-beat output queue follows the pipeline; the whole pipeline
//   holds while the queue is full, so s_tready drops only then. Input is
//   still taken while one finished result waits.
// Reset: aresetn low clears all valid bits and the queue and sets
//   singular_threshold to 1 (2^-16).
module matrix3x3_inverse (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,   // a00, a01, a02, a10, a11, a12, a20, a21, a22
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata,   // b00, b01, b02, b10, b11, b12, b20, b21, b22
    output logic [0:0]   m_tuser,   // invertible
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data   // singular_threshold
);

    localparam int STEPS = mi3_pkg::QUO_W;

    logic adv;
    logic [mi3_pkg::ELEM_W-1:0] thresh_reg;

    logic              ad_valid;
    mi3_pkg::adj_vec_t ad_adj;
    logic [mi3_pkg::DET_W-1:0] ad_det;

    logic               st_valid [STEPS+1];
    mi3_pkg::div_side_t st_side  [STEPS+1];
    mi3_pkg::lane_vec_t st_lanes [STEPS+1];

    mi3_pkg::out_beat_t out_beat;

    // threshold register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= mi3_pkg::THRESH_RESET;
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    assign s_tready = adv;

    mi3_adjdet u_adjdet (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_mat    (s_tdata),
        .out_valid (ad_valid),
        .out_adj   (ad_adj),
        .out_det   (ad_det)
    );

    mi3_divprep u_divprep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (ad_valid),
        .in_adj    (ad_adj),
        .in_det    (ad_det),
        .thresh    (thresh_reg),
        .out_valid (st_valid[0]),
        .out_side  (st_side[0]),
        .out_lanes (st_lanes[0])
    );

    // quotient chain, one bit per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        mi3_divstep u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (st_valid[i]),
            .in_side   (st_side[i]),
            .in_lanes  (st_lanes[i]),
            .out_valid (st_valid[i+1]),
            .out_side  (st_side[i+1]),
            .out_lanes (st_lanes[i+1])
        );
    end

    mi3_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (st_valid[STEPS]),
        .in_side  (st_side[STEPS]),
        .in_lanes (st_lanes[STEPS]),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_beat   (out_beat)
    );

    assign m_tdata    = out_beat.b;
    assign m_tuser[0] = out_beat.invertible;

`ifndef SYNTHESIS
    // a singular result carries all-zero elements
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("singular result with nonzero data");

    // nothing leaves the block right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // an invertible item always has a nonzero divisor
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid[0] && !st_side[0].singular |-> st_side[0].dmag != '0)
        else $error("zero divisor on invertible item");

    // an item at the end of the pipeline holds while the queue is full
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid[STEPS] && !adv |=> st_valid[STEPS])
        else $error("item dropped during stall");
`endif

endmodule

// File: tb/tb_matrix3x3_inverse.sv
// Self-checking testbench for the 3x3 matrix inverse: directed table, then random matrices.
module tb_matrix3x3_inverse;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIMIT_CYCLES = 400000;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          PHASE_ITEMS  = 184;
    localparam logic [31:0] ONE_Q        = 32'h0001_0000;
    localparam logic [31:0] THR_RESET    = mi3_pkg::THRESH_RESET;

    typedef struct {
        logic         invertible;
        logic [287:0] b;
    } inverse_t;

    typedef struct {
        logic [287:0] a;
        bit           typed;
        inverse_t     res;
    } vector_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [287:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;

    inverse_t     pending_inv[$];
    vector_t      vectors[$];
    logic [31:0]  threshold;
    int           send_idle;
    int           recv_idle;
    int           mismatches;
    int           cycles;

    matrix3x3_inverse i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Exact adjugate over determinant, quotient truncated and saturated to Q16.16
    function automatic inverse_t invert(logic [287:0] a, logic [31:0] thr);
        logic signed [127:0] e[9];
        logic signed [127:0] adj[9];
        logic signed [127:0] det;
        logic [127:0]        dmag;
        logic [127:0]        lim;
        logic [127:0]        mag;
        logic [127:0]        q;
        bit                  dneg;
        bit                  neg;
        inverse_t            r;
        for (int i = 0; i < 9; i++) begin
            e[i] = $signed(a[i*32 +: 32]);
        end
        adj[0] = e[4] * e[8] - e[7] * e[5];
        adj[1] = e[2] * e[7] - e[1] * e[8];
        adj[2] = e[1] * e[5] - e[2] * e[4];
        adj[3] = e[5] * e[6] - e[3] * e[8];
        adj[4] = e[0] * e[8] - e[6] * e[2];
        adj[5] = e[3] * e[2] - e[0] * e[5];
        adj[6] = e[3] * e[7] - e[6] * e[4];
        adj[7] = e[6] * e[1] - e[0] * e[7];
        adj[8] = e[0] * e[4] - e[3] * e[1];
        det  = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
        dneg = det[127];
        dmag = dneg ? -det : det;
        lim  = {96'd0, thr} << 32;
        r.invertible = 1'b0;
        r.b          = '0;
        if (dmag <= lim) begin
            return r;
        end
        r.invertible = 1'b1;
        for (int i = 0; i < 9; i++) begin
            if (adj[i] != 0) begin
                mag = adj[i][127] ? -adj[i] : adj[i];
                q   = (mag << 32) / dmag;
                neg = adj[i][127] != dneg;
                if (!neg) begin
                    r.b[i*32 +: 32] = (q > 128'h7FFF_FFFF) ? mi3_pkg::SAT_POS : q[31:0];
                end else begin
                    r.b[i*32 +: 32] = (q > 128'h8000_0000) ? mi3_pkg::SAT_NEG : -q[31:0];
                end
            end
        end
        return r;
    endfunction

    function automatic logic [287:0] diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
        logic [287:0] m;
        m = '0;
        m[0*32 +: 32] = d0;
        m[4*32 +: 32] = d1;
        m[8*32 +: 32] = d2;
        return m;
    endfunction

    function automatic logic [287:0] fill(logic [31:0] v);
        logic [287:0] m;
        for (int i = 0; i < 9; i++) m[i*32 +: 32] = v;
        return m;
    endfunction

    function automatic int small_val(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Mix of full-range, well-scaled, singular, near-singular and tiny matrices
    function automatic logic [287:0] random_matrix();
        logic [287:0] m;
        int           kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 9; i++) begin
            case (kind)
                0, 1, 2: m[i*32 +: 32] = $urandom;
                7:       m[i*32 +: 32] = small_val(1024);
                8:       m[i*32 +: 32] = (i % 4 == 0) ? $urandom : small_val(65536);
                default: m[i*32 +: 32] = small_val(262144);
            endcase
        end
        // make row 2 the sum of the upper rows, exact or nudged
        if (kind == 6 || kind == 9) begin
            for (int c = 0; c < 3; c++) begin
                m[(6+c)*32 +: 32] = $signed(m[c*32 +: 32]) + $signed(m[(3+c)*32 +: 32])
                                    + ((kind == 9) ? small_val(3) : 0);
            end
        end
        return m;
    endfunction

    task automatic add_vector(logic [287:0] a, bit typed, logic inv, logic [287:0] b);
        vector_t v;
        v.a              = a;
        v.typed          = typed;
        v.res.invertible = inv;
        v.res.b          = b;
        vectors.push_back(v);
    endtask

    // Present one matrix, hold it until accepted, then queue its inverse
    task automatic send_matrix(logic [287:0] a, bit typed, inverse_t res);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= a;
        do @(posedge aclk); while (!s_tready);
        pending_inv.push_back(typed ? res : invert(a, threshold));
        @(negedge aclk);
    endtask

    task automatic write_threshold(logic [31:0] v);
        s_tvalid <= 1'b0;
        wait (pending_inv.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        threshold = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver stall pattern
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Compare each result beat with the oldest expected inverse
    always @(posedge aclk) begin
        inverse_t exp_inv;
        bit       bad;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_inv.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat tdata=%h", m_tdata);
            end else begin
                exp_inv = pending_inv.pop_front();
                bad = (m_tuser[0] !== exp_inv.invertible);
                for (int i = 0; i < 9; i++) begin
                    if (m_tdata[i*32 +: 32] !== exp_inv.b[i*32 +: 32]) bad = 1'b1;
                end
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected inv=%b b=%h", exp_inv.invertible, exp_inv.b);
                        $display("          actual   inv=%b b=%h", m_tuser[0], m_tdata);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_matrix3x3_inverse failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] thr_list[6];
        logic [287:0] m;
        inverse_t     none;
        none        = '{1'b0, '0};
        mismatches  = 0;
        cycles      = 0;
        threshold   = THR_RESET;
        send_idle   = 0;
        recv_idle   = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        thr_list    = '{32'd0, 32'hFFFF_FFFF, ONE_Q, 32'h0000_0100, $urandom, THR_RESET};

        // Directed rows; expectations typed where obvious, under the reset threshold
        add_vector(diag(ONE_Q, ONE_Q, ONE_Q), 1, 1'b1, diag(ONE_Q, ONE_Q, ONE_Q));
        add_vector('0, 1, 1'b0, '0);
        add_vector(fill(32'h7FFF_FFFF), 1, 1'b0, '0);
        add_vector(fill(32'h8000_0000), 1, 1'b0, '0);
        add_vector(diag(32'h0002_0000, 32'h0002_0000, 32'h0002_0000), 1, 1'b1,
                   diag(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
        add_vector(diag(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000), 1, 1'b1,
                   diag(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000));
        add_vector(diag(32'd2, ONE_Q, ONE_Q), 1, 1'b1,
                   diag(mi3_pkg::SAT_POS, ONE_Q, ONE_Q));
        add_vector(diag(32'hFFFF_FFFE, ONE_Q, ONE_Q), 1, 1'b1,
                   diag(mi3_pkg::SAT_NEG, ONE_Q, ONE_Q));
        // determinant magnitude exactly at the threshold counts as singular
        add_vector(diag(32'hFFFF_FFFF, ONE_Q, ONE_Q), 1, 1'b0, '0);
        add_vector(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100), 1, 1'b0, '0);
        m = '0;
        m[1*32 +: 32] = ONE_Q;
        m[5*32 +: 32] = ONE_Q;
        m[6*32 +: 32] = ONE_Q;
        add_vector(m, 0, 1'b0, '0);
        for (int i = 0; i < 9; i++) m[i*32 +: 32] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        add_vector(m, 0, 1'b0, '0);
        for (int i = 0; i < 9; i++) m[i*32 +: 32] = (i % 4 == 0) ? 32'h7FFF_FFFF : 32'h0000_0001;
        add_vector(m, 0, 1'b0, '0);
        for (int i = 0; i < 9; i++) m[i*32 +: 32] = (i == 4) ? 32'h8000_0000 : ONE_Q * (i + 1);
        add_vector(m, 0, 1'b0, '0);
        for (int i = 0; i < 6; i++) add_vector(random_matrix(), 0, 1'b0, '0);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (vectors[k]) send_matrix(vectors[k].a, vectors[k].typed, vectors[k].res);

        // Random phases across threshold settings and idle patterns
        for (int p = 0; p < 6; p++) begin
            write_threshold(thr_list[p]);
            case (p % 3)
                0: begin send_idle = 32; recv_idle = 53; end
                1: begin send_idle = 53; recv_idle = 32; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == PHASE_ITEMS / 2) begin
                    // hold off until the pipeline has fully drained
                    s_tvalid <= 1'b0;
                    wait (pending_inv.size() == 0);
                    @(negedge aclk);
                end
                send_matrix(random_matrix(), 0, none);
            end
        end
        s_tvalid <= 1'b0;

        wait (pending_inv.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_inv.size() == 0) begin
            $display("tb_matrix3x3_inverse passed");
        end else begin
            $display("tb_matrix3x3_inverse failed");
        end
        $finish;
    end

endmodule
